### rtl/core/sqvs_pkg.sv
package sqvs_pkg;

    // Fraction bits of positions, coefficients and uv
    localparam int FRAC_BITS = 16;
    localparam int UV_W      = FRAC_BITS + 1;
    localparam logic [UV_W-1:0] UV_ONE = UV_W'(1) << FRAC_BITS;

    // Quotient bits resolved per divider stage
    localparam int DIV_STEPS = 4;

    // Configuration register indexes
    localparam logic [2:0] REG_TEX_WIDTH  = 3'd0;
    localparam logic [2:0] REG_TEX_HEIGHT = 3'd1;
    localparam logic [2:0] REG_SCALE_XX   = 3'd2;
    localparam logic [2:0] REG_SHEAR_XY   = 3'd3;
    localparam logic [2:0] REG_SHEAR_YX   = 3'd4;
    localparam logic [2:0] REG_SCALE_YY   = 3'd5;
    localparam logic [2:0] REG_OFFSET_X   = 3'd6;
    localparam logic [2:0] REG_OFFSET_Y   = 3'd7;

    // Corner codes
    localparam logic [1:0] CORNER_BL = 2'd0;
    localparam logic [1:0] CORNER_BR = 2'd1;
    localparam logic [1:0] CORNER_TL = 2'd2;
    localparam logic [1:0] CORNER_TR = 2'd3;

    typedef struct packed {
        logic        [9:0]  quad_slot;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] depth_z;
        logic        [15:0] rect_x;
        logic        [15:0] rect_y;
        logic        [15:0] rect_w;
        logic        [15:0] rect_h;
        logic               flip_x;
        logic               flip_y;
        logic               rotated;
    } sprite_t;

    typedef struct packed {
        logic        [9:0]      slot_out;
        logic        [1:0]      corner;
        logic signed [31:0]     vert_x;
        logic signed [31:0]     vert_y;
        logic signed [31:0]     vert_z;
        logic        [UV_W-1:0] tex_u;
        logic        [UV_W-1:0] tex_v;
        logic                   last;
    } vertex_t;

    typedef struct packed {
        logic        [15:0] tex_width;
        logic        [15:0] tex_height;
        logic signed [31:0] scale_xx;
        logic signed [31:0] shear_xy;
        logic signed [31:0] shear_yx;
        logic signed [31:0] scale_yy;
        logic signed [31:0] offset_x;
        logic signed [31:0] offset_y;
    } cfg_t;

    // Per-vertex fields that ride along the pipeline untouched
    typedef struct packed {
        logic        [9:0]  slot;
        logic        [1:0]  corner;
        logic signed [31:0] z;
        logic               last;
    } meta_t;

    // One corner leaving the sequencer
    typedef struct packed {
        meta_t              meta;
        logic signed [31:0] gx;
        logic signed [31:0] gy;
        logic        [16:0] u_num;
        logic        [16:0] v_num;
    } corner_item_t;

    // Partial restoring division
    typedef struct packed {
        logic [15:0] rem;
        logic [15:0] quo;
        logic        sat;
    } div_t;

    // Start a uv division; a quotient of one or more saturates at once
    function automatic div_t div_init(input logic [16:0] num, input logic [15:0] den);
        div_t d;
        d.quo = '0;
        d.sat = (num >= {1'b0, den});
        d.rem = d.sat ? 16'd0 : num[15:0];
        return d;
    endfunction

    // Resolve DIV_STEPS more quotient bits
    function automatic div_t div_step(input div_t din, input logic [15:0] den);
        div_t        d;
        logic [16:0] r2;
        d = din;
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            r2 = {d.rem, 1'b0};
            if (r2 >= {1'b0, den})
            begin
                r2 = r2 - {1'b0, den};
                d.quo = {d.quo[14:0], 1'b1};
            end
            else
            begin
                d.quo = {d.quo[14:0], 1'b0};
            end
            d.rem = r2[15:0];
        end
        return d;
    endfunction

    // Clamp to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
        if (v > 50'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (v < -50'sd2147483648)
            return 32'sh80000000;
        else
            return 32'(v);
    endfunction

endpackage

### rtl/core/sqvs_sprite_if.sv
interface sqvs_sprite_if import sqvs_pkg::*; ();
    logic    valid;
    logic    ready;
    sprite_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/sqvs_vertex_if.sv
interface sqvs_vertex_if import sqvs_pkg::*; ();
    logic    valid;
    logic    ready;
    vertex_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/sprite_quad_vertex_setup.sv
// The first vertex leaves through the corner sequencer register and then four pipeline
// stages; then one vertex per cycle while the vertex output is not stalled.
// A new sprite is taken as the last corner of the current one is accepted downstream.
// The uv divider resolves 4 quotient bits per stage over the same 4 stages.
// Reset (rst_n low, asynchronous) empties the pipeline and loads register defaults.
module sprite_quad_vertex_setup import sqvs_pkg::*; #(
    parameter int MAX_QUADS = 1024
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    sqvs_sprite_if.sink   sprite,
    sqvs_vertex_if.source vertex
);

    cfg_t         cfg;
    logic         c_valid, c_ready;
    corner_item_t c_item;

    sqvs_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sqvs_corner_seq #(.MAX_QUADS(MAX_QUADS)) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .sprite    (sprite),
        .out_valid (c_valid),
        .out_ready (c_ready),
        .out_item  (c_item)
    );

    sqvs_xform_pipe u_pipe (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (c_valid),
        .in_ready (c_ready),
        .in_item  (c_item),
        .vertex   (vertex)
    );

endmodule

### rtl/core/sqvs_regs.sv
module sqvs_regs import sqvs_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = paddr[4:2];
    assign cfg    = cfg_reg;

    // Register file write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tex_width  <= 16'd1;
            cfg_reg.tex_height <= 16'd1;
            cfg_reg.scale_xx   <= 32'sd65536;
            cfg_reg.shear_xy   <= '0;
            cfg_reg.shear_yx   <= '0;
            cfg_reg.scale_yy   <= 32'sd65536;
            cfg_reg.offset_x   <= '0;
            cfg_reg.offset_y   <= '0;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_TEX_WIDTH:  cfg_reg.tex_width  <= pwdata[15:0];
                REG_TEX_HEIGHT: cfg_reg.tex_height <= pwdata[15:0];
                REG_SCALE_XX:   cfg_reg.scale_xx   <= pwdata;
                REG_SHEAR_XY:   cfg_reg.shear_xy   <= pwdata;
                REG_SHEAR_YX:   cfg_reg.shear_yx   <= pwdata;
                REG_SCALE_YY:   cfg_reg.scale_yy   <= pwdata;
                REG_OFFSET_X:   cfg_reg.offset_x   <= pwdata;
                REG_OFFSET_Y:   cfg_reg.offset_y   <= pwdata;
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        case (idx)
            REG_TEX_WIDTH:  prdata = {16'd0, cfg_reg.tex_width};
            REG_TEX_HEIGHT: prdata = {16'd0, cfg_reg.tex_height};
            REG_SCALE_XX:   prdata = cfg_reg.scale_xx;
            REG_SHEAR_XY:   prdata = cfg_reg.shear_xy;
            REG_SHEAR_YX:   prdata = cfg_reg.shear_yx;
            REG_SCALE_YY:   prdata = cfg_reg.scale_yy;
            REG_OFFSET_X:   prdata = cfg_reg.offset_x;
            REG_OFFSET_Y:   prdata = cfg_reg.offset_y;
            default:        prdata = '0;
        endcase
    end

endmodule

### rtl/core/sqvs_corner_seq.sv
module sqvs_corner_seq import sqvs_pkg::*; #(
    parameter int MAX_QUADS = 1024
) (
    input  logic         clk,
    input  logic         rst_n,
    sqvs_sprite_if.sink  sprite,
    output logic         out_valid,
    input  logic         out_ready,
    output corner_item_t out_item
);

    logic               busy_reg, busy_next;
    logic [1:0]         k_reg, k_next;
    logic [9:0]         slot_reg;
    logic signed [31:0] x1_reg, x2_reg, y1_reg, y2_reg, z_reg;
    logic [16:0]        ul_reg, ur_reg, vt_reg, vb_reg;
    logic               fx_reg, fy_reg, rot_reg;

    logic               in_fire, adv;
    logic signed [33:0] x2w, y2w;
    logic               u_right, v_top;

    assign adv          = busy_reg & out_ready;
    assign sprite.ready = ~busy_reg | (adv & (k_reg == CORNER_TR));
    assign in_fire      = sprite.valid & sprite.ready;

    // Far edges: position plus width or height in whole units, clamped when captured
    assign x2w = 34'(sprite.data.pos_x)
               + signed'({2'b00, sprite.data.rect_w, {FRAC_BITS{1'b0}}});
    assign y2w = 34'(sprite.data.pos_y)
               + signed'({2'b00, sprite.data.rect_h, {FRAC_BITS{1'b0}}});

    // Corner counter
    always_comb
    begin
        busy_next = busy_reg;
        k_next    = k_reg;
        if (adv)
        begin
            k_next = k_reg + 2'd1;
            if (k_reg == CORNER_TR)
                busy_next = in_fire;
        end
        else if (in_fire)
        begin
            busy_next = 1'b1;
            k_next    = CORNER_BL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            k_reg    <= CORNER_BL;
        end
        else
        begin
            busy_reg <= busy_next;
            k_reg    <= k_next;
        end
    end

    // Capture the sprite
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            slot_reg <= 10'(32'(sprite.data.quad_slot) % MAX_QUADS);
            x1_reg   <= sprite.data.pos_x;
            y1_reg   <= sprite.data.pos_y;
            x2_reg   <= sat32(50'(x2w));
            y2_reg   <= sat32(50'(y2w));
            z_reg    <= sprite.data.depth_z;
            ul_reg   <= {1'b0, sprite.data.rect_x};
            ur_reg   <= {1'b0, sprite.data.rect_x} + {1'b0, sprite.data.rect_w};
            vt_reg   <= {1'b0, sprite.data.rect_y};
            vb_reg   <= {1'b0, sprite.data.rect_y} + {1'b0, sprite.data.rect_h};
            fx_reg   <= sprite.data.flip_x;
            fy_reg   <= sprite.data.flip_y;
            rot_reg  <= sprite.data.rotated;
        end
    end

    // Pick geometry and texture edges for the current corner
    always_comb
    begin
        u_right = (rot_reg ? ~k_reg[1] : k_reg[0]) ^ fx_reg;
        v_top   = (rot_reg ? ~k_reg[0] : k_reg[1]) ^ fy_reg;
        out_item.meta.slot   = slot_reg;
        out_item.meta.corner = k_reg;
        out_item.meta.z      = z_reg;
        out_item.meta.last   = (k_reg == CORNER_TR);
        out_item.gx          = k_reg[0] ? x2_reg : x1_reg;
        out_item.gy          = k_reg[1] ? y2_reg : y1_reg;
        out_item.u_num       = u_right ? ur_reg : ul_reg;
        out_item.v_num       = v_top ? vt_reg : vb_reg;
    end

    assign out_valid = busy_reg;

endmodule

### rtl/core/sqvs_xform_pipe.sv
module sqvs_xform_pipe import sqvs_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  cfg_t         cfg,
    input  logic         in_valid,
    output logic         in_ready,
    input  corner_item_t in_item,
    sqvs_vertex_if.source vertex
);

    typedef struct packed {
        meta_t              meta;
        logic signed [63:0] pxx, pyx, pxy, pyy;
        div_t               du, dv;
    } st1_t;

    typedef struct packed {
        meta_t              meta;
        logic signed [47:0] axx, ayx, axy, ayy;
        div_t               du, dv;
    } st2_t;

    typedef struct packed {
        meta_t              meta;
        logic signed [31:0] vx, vy;
        div_t               du, dv;
    } st3_t;

    logic    v1_reg, v2_reg, v3_reg, v4_reg;
    logic    r1, r2, r3, r4;
    st1_t    s1_reg;
    st2_t    s2_reg;
    st3_t    s3_reg;
    vertex_t s4_reg;
    div_t    du4, dv4;

    logic [15:0]        den_u, den_v;
    logic signed [63:0] rnd_xx, rnd_yx, rnd_xy, rnd_yy;
    localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

    // A zero atlas size acts as one
    assign den_u = (cfg.tex_width  == 16'd0) ? 16'd1 : cfg.tex_width;
    assign den_v = (cfg.tex_height == 16'd0) ? 16'd1 : cfg.tex_height;

    // Stage advance: a stage loads when empty or when it drains
    assign r4       = ~v4_reg | vertex.ready;
    assign r3       = ~v3_reg | r4;
    assign r2       = ~v2_reg | r3;
    assign r1       = ~v1_reg | r2;
    assign in_ready = r1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (r1) v1_reg <= in_valid;
            if (r2) v2_reg <= v1_reg;
            if (r3) v3_reg <= v2_reg;
            if (r4) v4_reg <= v3_reg;
        end
    end

    // Stage 1: products, divider start
    always_ff @(posedge clk)
    begin
        if (r1)
        begin
            s1_reg.meta <= in_item.meta;
            s1_reg.pxx  <= 64'(in_item.gx) * 64'(cfg.scale_xx);
            s1_reg.pyx  <= 64'(in_item.gy) * 64'(cfg.shear_yx);
            s1_reg.pxy  <= 64'(in_item.gx) * 64'(cfg.shear_xy);
            s1_reg.pyy  <= 64'(in_item.gy) * 64'(cfg.scale_yy);
            s1_reg.du   <= div_step(div_init(in_item.u_num, den_u), den_u);
            s1_reg.dv   <= div_step(div_init(in_item.v_num, den_v), den_v);
        end
    end

    // Round halves up at the fraction point
    assign rnd_xx = (s1_reg.pxx + HALF) >>> FRAC_BITS;
    assign rnd_yx = (s1_reg.pyx + HALF) >>> FRAC_BITS;
    assign rnd_xy = (s1_reg.pxy + HALF) >>> FRAC_BITS;
    assign rnd_yy = (s1_reg.pyy + HALF) >>> FRAC_BITS;

    // Stage 2: rounded products
    always_ff @(posedge clk)
    begin
        if (r2)
        begin
            s2_reg.meta <= s1_reg.meta;
            s2_reg.axx  <= 48'(rnd_xx);
            s2_reg.ayx  <= 48'(rnd_yx);
            s2_reg.axy  <= 48'(rnd_xy);
            s2_reg.ayy  <= 48'(rnd_yy);
            s2_reg.du   <= div_step(s1_reg.du, den_u);
            s2_reg.dv   <= div_step(s1_reg.dv, den_v);
        end
    end

    // Stage 3: sum with offset, saturate
    always_ff @(posedge clk)
    begin
        if (r3)
        begin
            s3_reg.meta <= s2_reg.meta;
            s3_reg.vx   <= sat32(50'(s2_reg.axx) + 50'(s2_reg.ayx) + 50'(cfg.offset_x));
            s3_reg.vy   <= sat32(50'(s2_reg.axy) + 50'(s2_reg.ayy) + 50'(cfg.offset_y));
            s3_reg.du   <= div_step(s2_reg.du, den_u);
            s3_reg.dv   <= div_step(s2_reg.dv, den_v);
        end
    end

    assign du4 = div_step(s3_reg.du, den_u);
    assign dv4 = div_step(s3_reg.dv, den_v);

    // Stage 4: output register
    always_ff @(posedge clk)
    begin
        if (r4)
        begin
            s4_reg.slot_out <= s3_reg.meta.slot;
            s4_reg.corner   <= s3_reg.meta.corner;
            s4_reg.vert_x   <= s3_reg.vx;
            s4_reg.vert_y   <= s3_reg.vy;
            s4_reg.vert_z   <= s3_reg.meta.z;
            s4_reg.tex_u    <= du4.sat ? UV_ONE : {1'b0, du4.quo};
            s4_reg.tex_v    <= dv4.sat ? UV_ONE : {1'b0, dv4.quo};
            s4_reg.last     <= s3_reg.meta.last;
        end
    end

    assign vertex.valid = v4_reg;
    assign vertex.data  = s4_reg;

endmodule

### rtl/core/sqvs_checker.sv
module sqvs_checker import sqvs_pkg::*; (
    input logic      clk,
    input logic      rst_n,
    input logic      out_valid,
    input logic      out_ready,
    input vertex_t   out_data
);

    // Stalled beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("vertex beat changed while stalled");

    // Last marks exactly the top-right corner
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.last == (out_data.corner == CORNER_TR)))
        else $error("last flag does not match corner");

    // Texture coordinates never exceed one
    a_uv: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.tex_u <= UV_ONE) && (out_data.tex_v <= UV_ONE))
        else $error("uv above one");

    // Corners follow each other in order
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_data.last |=>
            !out_valid || (out_data.corner == $past(out_data.corner) + 2'd1))
        else $error("corner out of order");

endmodule

bind sprite_quad_vertex_setup sqvs_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (vertex.valid),
    .out_ready (vertex.ready),
    .out_data  (vertex.data)
);
